### rtl/ttm_pkg.sv
// shared types and constants for the tick to microsecond converter
`timescale 1ns / 1ps

package ttm_pkg;

    // field widths
    localparam int TicksW  = 32;
    localparam int RateW   = 32;
    localparam int UsW     = 32;
    localparam int StatusW = 3;

    // one million = 15625 * 2^6
    localparam int UsOddW  = 14;
    localparam logic [UsOddW-1:0] UsOdd = 14'd15625;
    localparam int UsShift = 6;

    // widths of the product chain
    localparam int Prod1W = TicksW + RateW;
    localparam int Prod2W = Prod1W + UsOddW;
    localparam int DvdW   = Prod2W + UsShift;

    // one restoring division step per cell, one cell per dividend bit
    localparam int DivSteps = DvdW;
    // cycles from accepted start to the done strobe
    localparam int Latency  = DivSteps + 3;

    // result status codes
    typedef enum logic [StatusW-1:0] {
        ST_OK          = 3'd0,
        ST_ZERO_RATE   = 3'd1,
        ST_INEXACT     = 3'd2,
        ST_ZERO_RESULT = 3'd3,
        ST_TOO_LARGE   = 3'd4
    } t_status;

    // configuration register index
    typedef enum logic {
        CFG_NUMERATOR   = 1'b0,
        CFG_DENOMINATOR = 1'b1
    } t_cfg_idx;

    // data handed from one division cell to the next
    typedef struct packed {
        logic             vld;
        logic             ovf;
        logic [UsW-1:0]   quo;
        logic [RateW-1:0] rem;
        logic [DvdW-1:0]  dvd;
    } t_cell;

endpackage

### rtl/ttm_mul.sv
// two-stage multiplier forming ticks * denominator * 15625
`timescale 1ns / 1ps

module ttm_mul
    import ttm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [TicksW-1:0] i_ticks,
    input  logic [RateW-1:0]  i_den,
    output logic              o_vld,
    output logic [Prod2W-1:0] o_prod
);

    logic              r_vld1;
    logic              r_vld2;
    logic [Prod1W-1:0] r_p1;
    logic [Prod2W-1:0] r_p2;
    logic [Prod1W-1:0] n_p1;
    logic [Prod2W-1:0] n_p2;

    // 32 by 32 product, then by the odd part of one million
    always_comb begin
        n_p1 = Prod1W'(i_ticks) * Prod1W'(i_den);
        n_p2 = Prod2W'(r_p1) * Prod2W'(UsOdd);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_p1 <= n_p1;
        r_p2 <= n_p2;
    end

    assign o_vld  = r_vld2;
    assign o_prod = r_p2;

endmodule

### rtl/ttm_cell.sv
// one restoring division step: takes one dividend bit, yields one quotient bit
`timescale 1ns / 1ps

module ttm_cell
    import ttm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RateW-1:0] i_num,
    input  t_cell            i_in,
    output t_cell            o_out
);

    logic             r_vld;
    logic             r_ovf;
    logic [UsW-1:0]   r_quo;
    logic [RateW-1:0] r_rem;
    logic [DvdW-1:0]  r_dvd;

    logic             n_ovf;
    logic [UsW-1:0]   n_quo;
    logic [RateW-1:0] n_rem;
    logic [DvdW-1:0]  n_dvd;

    logic [RateW:0]   trial;
    logic [RateW:0]   diff;
    logic             ge;

    // shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {i_in.rem, i_in.dvd[DvdW-1]};
        diff  = trial - {1'b0, i_num};
        ge    = (trial >= {1'b0, i_num});
        n_rem = ge ? diff[RateW-1:0] : trial[RateW-1:0];
        n_dvd = {i_in.dvd[DvdW-2:0], 1'b0};
        // a quotient bit pushed off the top means the result exceeds 32 bits
        n_ovf = i_in.ovf | i_in.quo[UsW-1];
        n_quo = {i_in.quo[UsW-2:0], ge};
    end

    // beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_in.vld;
        end
    end

    // partial remainder, quotient and dividend
    always_ff @(posedge i_clk) begin
        r_ovf <= n_ovf;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    always_comb begin
        o_out.vld = r_vld;
        o_out.ovf = r_ovf;
        o_out.quo = r_quo;
        o_out.rem = r_rem;
        o_out.dvd = r_dvd;
    end

endmodule

### rtl/tick_to_microsecond_converter_core.sv
// tick to microsecond converter: multiplier, chain of division cells, result check
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  command  | start, busy, i_ticks                    | taken when start & !busy
//  result   | o_done, o_microseconds, o_status        | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata        | written when i_cfg_we is high
//
// A beat is accepted every cycle; busy is high only during reset.
// Each result passes through two multiplier stages, 84 division cells (one per bit
// of the 84-bit dividend) and the result register.
// Synchronous active-low reset clears all valids and sets both rate registers to 1.
// The receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps

module tick_to_microsecond_converter_core
    import ttm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [TicksW-1:0]   i_ticks,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [RateW-1:0]    i_cfg_wdata,
    output logic                o_done,
    output logic [UsW-1:0]      o_microseconds,
    output logic [StatusW-1:0]  o_status
);

    logic [RateW-1:0]  r_num;
    logic [RateW-1:0]  r_den;
    logic              acc;
    logic              mul_vld;
    logic [Prod2W-1:0] mul_prod;
    t_cell             chain [0:DivSteps];

    logic              r_done;
    logic [UsW-1:0]    r_us;
    t_status           r_status;
    logic [UsW-1:0]    n_us;
    t_status           n_status;

    assign busy = !i_rst_n;
    assign acc  = start && !busy;

    // rate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= RateW'(1);
            r_den <= RateW'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMERATOR:   r_num <= i_cfg_wdata;
                CFG_DENOMINATOR: r_den <= i_cfg_wdata;
                default:         r_num <= r_num;
            endcase
        end
    end

    // dividend = ticks * denominator * 1000000
    ttm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (acc),
        .i_ticks (i_ticks),
        .i_den   (r_den),
        .o_vld   (mul_vld),
        .o_prod  (mul_prod)
    );

    // chain head
    always_comb begin
        chain[0].vld = mul_vld;
        chain[0].ovf = 1'b0;
        chain[0].quo = '0;
        chain[0].rem = '0;
        chain[0].dvd = {mul_prod, UsShift'(0)};
    end

    // division cells
    for (genvar g = 0; g < DivSteps; g++) begin : g_cell
        ttm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_num   (r_num),
            .i_in    (chain[g]),
            .o_out   (chain[g+1])
        );
    end

    // status in priority order
    always_comb begin
        n_us = '0;
        priority if (r_num == '0 || r_den == '0) begin
            n_status = ST_ZERO_RATE;
        end else if (chain[DivSteps].rem != '0) begin
            n_status = ST_INEXACT;
        end else if (chain[DivSteps].ovf) begin
            n_status = ST_TOO_LARGE;
        end else if (chain[DivSteps].quo == '0) begin
            n_status = ST_ZERO_RESULT;
        end else begin
            n_status = ST_OK;
            n_us     = chain[DivSteps].quo;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain[DivSteps].vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_us     <= n_us;
        r_status <= n_status;
    end

    assign o_done         = r_done;
    assign o_microseconds = r_us;
    assign o_status       = r_status;

    // every accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##Latency o_done)
        else $error("result missing after accepted start");

    // failures carry a zero result
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_microseconds == '0))
        else $error("nonzero microseconds on failure");

    // a successful conversion is never zero
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK) |-> (o_microseconds != '0))
        else $error("zero microseconds with ok status");

endmodule
